// ===== hw/rtl/i2c_target_register_file_core_macros.svh =====
// ----------------------------------------------------------------------------
// I2C target register file assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_TARGET_REGISTER_FILE_CORE_MACROS_SVH
`define I2C_TARGET_REGISTER_FILE_CORE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define I2CTRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2ctrf assertion failed");

// consequent holds in the cycle after the antecedent
`define I2CTRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2ctrf assertion failed");

`endif

// ===== hw/rtl/i2ctrf_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C target register file package
// Bus event codes, widths and the operation passed from control to storage.
// ----------------------------------------------------------------------------
package i2ctrf_pkg;

    // default number of byte registers
    localparam int DEFAULT_STORE_DEPTH = 32;

    // register pointer width
    localparam int PTR_W = 8;

    // byte-level bus event codes, other codes behave as nack
    typedef enum logic [2:0] {
        EV_WR_ADDR = 3'd0,
        EV_WR_DATA = 3'd1,
        EV_RD_ADDR = 3'd2,
        EV_RD_DATA = 3'd3,
        EV_OTHER   = 3'd4
    } bus_event_t;

    // one storage operation per transaction
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [PTR_W-1:0] idx;
        logic [7:0]       data;
    } store_op_t;

endpackage

// ===== hw/rtl/i2c_target_register_file_core.sv =====
// Path: an accepted bus event is held in the input register, its result then
// in the result register. Throughput: one bus event per cycle unless out_ready
// holds the result, set by the pointer update and the one-write-or-read memory
// port per transaction. Reset: pointer zero, write phase idle, every register
// byte reads as zero (per-entry valid bits), pipeline empty; no clearing pass.
// ----------------------------------------------------------------------------
// I2C target register file core
// Byte-level I2C target register map with auto-incrementing pointer.
// ----------------------------------------------------------------------------
module i2c_target_register_file_core #(
    parameter int STORE_DEPTH = i2ctrf_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] bus_event,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       tx_valid,
    output logic [7:0] tx_byte
);

    logic                  s1_valid_reg;
    logic [2:0]            s1_event_reg;
    logic [7:0]            s1_byte_reg;
    logic                  advance;
    i2ctrf_pkg::store_op_t op;

    // the input stage moves on when the result register is free
    assign advance  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_event_reg <= bus_event;
            s1_byte_reg  <= rx_byte;
        end
    end

    // pointer and phase control
    i2ctrf_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .bus_event (s1_event_reg),
        .rx_byte   (s1_byte_reg),
        .op        (op)
    );

    // register storage and result
    i2ctrf_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .op        (op),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte)
    );

endmodule

// ===== hw/rtl/i2ctrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// I2C target register file control
// Holds the register pointer and write phase, decodes one bus event per
// transaction into a storage operation.
// ----------------------------------------------------------------------------
`include "i2c_target_register_file_core_macros.svh"

module i2ctrf_ctrl #(
    parameter int STORE_DEPTH = i2ctrf_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic [2:0]                          bus_event,
    input  logic [7:0]                          rx_byte,
    output i2ctrf_pkg::store_op_t               op
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_POINTER = 2'd1,
        PH_DATA    = 2'd2
    } phase_t;

    localparam logic [i2ctrf_pkg::PTR_W:0] DEPTH_EXT = (i2ctrf_pkg::PTR_W + 1)'(STORE_DEPTH);

    phase_t                       phase_reg;
    phase_t                       phase_next;
    logic [i2ctrf_pkg::PTR_W-1:0] ptr_reg;
    logic [i2ctrf_pkg::PTR_W-1:0] ptr_next;
    logic [i2ctrf_pkg::PTR_W-1:0] wrap_idx;
    logic [i2ctrf_pkg::PTR_W:0]   inc_ext;

    // pointer at or beyond the store wraps to zero before the access
    always_comb
    begin
        wrap_idx = ({1'b0, ptr_reg} >= DEPTH_EXT) ? '0 : ptr_reg;
        inc_ext  = {1'b0, wrap_idx} + (i2ctrf_pkg::PTR_W + 1)'(1);
    end

    // event decode and next pointer / phase
    always_comb
    begin
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        op.wr_en   = 1'b0;
        op.rd_en   = 1'b0;
        op.idx     = wrap_idx;
        op.data    = rx_byte;
        unique case (bus_event)
            i2ctrf_pkg::EV_WR_ADDR:
            begin
                ptr_next   = '0;
                phase_next = PH_POINTER;
            end
            i2ctrf_pkg::EV_WR_DATA:
            begin
                if (phase_reg == PH_POINTER)
                begin
                    ptr_next   = rx_byte;
                    phase_next = PH_DATA;
                end
                else
                begin
                    op.wr_en = 1'b1;
                    ptr_next = (inc_ext >= DEPTH_EXT) ? '0 : inc_ext[i2ctrf_pkg::PTR_W-1:0];
                end
            end
            i2ctrf_pkg::EV_RD_ADDR, i2ctrf_pkg::EV_RD_DATA:
            begin
                op.rd_en = 1'b1;
                ptr_next = inc_ext[i2ctrf_pkg::PTR_W-1:0];
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // pointer and phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ptr_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
        end
    end

    // checks
    `I2CTRF_ASSERT_NEXT(a_wr_addr_sets_pointer_phase,
        fire && bus_event == i2ctrf_pkg::EV_WR_ADDR,
        phase_reg == PH_POINTER && ptr_reg == '0)
    `I2CTRF_ASSERT_NEXT(a_write_leaves_pointer_in_range,
        fire && op.wr_en,
        {1'b0, ptr_reg} < DEPTH_EXT)

endmodule

// ===== hw/rtl/i2ctrf_store.sv =====
// ----------------------------------------------------------------------------
// I2C target register file storage
// Byte register memory with per-entry valid bits and the result register.
// ----------------------------------------------------------------------------
`include "i2c_target_register_file_core_macros.svh"

module i2ctrf_store #(
    parameter int STORE_DEPTH = i2ctrf_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  i2ctrf_pkg::store_op_t op,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  tx_valid,
    output logic [7:0]            tx_byte
);

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0]             mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;
    logic [IDX_W-1:0]       addr;
    logic                   out_valid_reg;
    logic                   tx_valid_reg;
    logic [7:0]             tx_byte_reg;

    assign addr = op.idx[IDX_W-1:0];

    // memory write and registered read into the result register
    always_ff @(posedge clk)
    begin
        if (advance && op.wr_en)
        begin
            mem[addr] <= op.data;
        end
        if (advance)
        begin
            tx_valid_reg <= op.rd_en;
            tx_byte_reg  <= (op.rd_en && vld_reg[addr]) ? mem[addr] : '0;
        end
    end

    // entry valid bits and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance && op.wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_valid  = tx_valid_reg;
    assign tx_byte   = tx_byte_reg;

    // checks
    `I2CTRF_ASSERT_NEXT(a_read_gives_tx_result,
        advance && op.rd_en,
        out_valid_reg && tx_valid_reg)
    `I2CTRF_ASSERT_SAME(a_no_tx_means_zero_byte,
        out_valid_reg && !tx_valid_reg,
        tx_byte_reg == '0)

endmodule

// ===== verif/tb_i2c_target_register_file_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target register file core testbench
// Drives byte-level bus events through valid/ready, predicts every result
// transaction from a local model of the register map and its auto-increment
// pointer, and checks each result field by field under random idling.
// ----------------------------------------------------------------------------
module tb_i2c_target_register_file_core;

    localparam int STORE_DEPTH      = i2ctrf_pkg::DEFAULT_STORE_DEPTH;
    localparam int RANDOM_ITEMS     = 1050;
    localparam int DRAIN_AT         = 600;
    localparam int LONG_HOLD_AT     = 250;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 10;
    localparam int WATCHDOG_LIMIT   = 5000;

    // bus event codes of the block
    localparam logic [2:0] EV_WR_ADDR = i2ctrf_pkg::EV_WR_ADDR;
    localparam logic [2:0] EV_WR_DATA = i2ctrf_pkg::EV_WR_DATA;
    localparam logic [2:0] EV_RD_ADDR = i2ctrf_pkg::EV_RD_ADDR;
    localparam logic [2:0] EV_RD_DATA = i2ctrf_pkg::EV_RD_DATA;
    localparam logic [2:0] EV_OTHER   = i2ctrf_pkg::EV_OTHER;

    // bus event codes above the named ones act as nack
    localparam logic [2:0] EV_CODE_MAX = 3'd7;

    // write phase of the model
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_PTR  = 2'd1;
    localparam logic [1:0] PHASE_DATA = 2'd2;

    typedef struct packed {
        logic [2:0] code;
        logic [7:0] data;
        logic [7:0] gap;
        logic       drain;
    } bus_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
    } tx_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] bus_event = EV_OTHER;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       tx_valid;
    logic [7:0] tx_byte;

    i2c_target_register_file_core #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .bus_event(bus_event),
        .rx_byte  (rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tx_valid (tx_valid),
        .tx_byte  (tx_byte)
    );

    // bus events waiting to be driven, and results still owed by the block
    bus_item_t  pending[$];
    tx_result_t tx_expected[$];

    // model state of the register map
    logic [7:0] model_mem [STORE_DEPTH];
    logic [7:0] model_ptr;
    logic [1:0] model_phase;

    int         in_count;
    int         out_count;
    int         fail_count;
    int         bus_events_added;

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // queue one bus event
    task automatic add_item(input logic [2:0] code, input logic [7:0] data, input bit quiet);
        bus_item_t item;
        item.code  = code;
        item.data  = data;
        item.gap   = quiet ? 8'd0 : 8'(pick_gap());
        item.drain = (pending.size() == DRAIN_AT);
        pending.push_back(item);
        bus_events_added++;
    endtask

    // model: apply one bus event and record the byte sent back to the master
    task automatic apply_bus_event(input logic [2:0] code, input logic [7:0] data);
        tx_result_t res;
        res.tx_valid = 1'b0;
        res.tx_byte  = 8'h00;
        case (code)
            EV_WR_ADDR:
            begin
                model_ptr   = 8'h00;
                model_phase = PHASE_PTR;
            end
            EV_WR_DATA:
            begin
                if (model_phase == PHASE_PTR)
                begin
                    // first byte after the address phase is the pointer
                    model_ptr   = data;
                    model_phase = PHASE_DATA;
                end
                else
                begin
                    if (model_ptr >= STORE_DEPTH)
                        model_ptr = 8'h00;
                    model_mem[model_ptr] = data;
                    model_ptr = model_ptr + 8'd1;
                    if (model_ptr >= STORE_DEPTH)
                        model_ptr = 8'h00;
                end
            end
            EV_RD_ADDR, EV_RD_DATA:
            begin
                // read wraps before access, may leave pointer at the depth
                if (model_ptr >= STORE_DEPTH)
                    model_ptr = 8'h00;
                res.tx_valid = 1'b1;
                res.tx_byte  = model_mem[model_ptr];
                model_ptr    = model_ptr + 8'd1;
            end
            default:
            begin
            end
        endcase
        tx_expected.push_back(res);
    endtask

    // driver
    int        idle_left;
    bit        gap_loaded;
    bit        offering;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            bus_event  <= EV_OTHER;
            rx_byte    <= 8'h00;
            in_count   = 0;
            idle_left  = 0;
            gap_loaded = 1'b0;
        end
        else
        begin
            offering = in_valid;
            // transaction accepted on the input side
            if (in_valid && in_ready)
            begin
                apply_bus_event(bus_event, rx_byte);
                in_count++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (!gap_loaded && pending.size() > 0)
                begin
                    idle_left  = pending[0].gap;
                    gap_loaded = 1'b1;
                end
                if (pending.size() == 0)
                    in_valid <= 1'b0;
                else if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending[0].drain && in_count != out_count)
                    in_valid <= 1'b0;
                else
                begin
                    in_valid   <= 1'b1;
                    bus_event  <= pending[0].code;
                    rx_byte    <= pending[0].data;
                    gap_loaded = 1'b0;
                    void'(pending.pop_front());
                end
            end
        end
    end

    // monitor and receiver back-pressure
    tx_result_t head_res;
    int         stall_left;
    bit         long_hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            out_count      <= 0;
            stall_left     = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            // check a result transaction against the oldest expectation
            if (out_valid && out_ready)
            begin
                out_count <= out_count + 1;
                if (tx_expected.size() == 0)
                begin
                    $error("unexpected result: tx_valid %0d tx_byte 0x%02h", tx_valid, tx_byte);
                    fail_count++;
                end
                else
                begin
                    head_res = tx_expected.pop_front();
                    if (tx_valid !== head_res.tx_valid)
                    begin
                        $error("tx_valid: expected %0d, actual %0d", head_res.tx_valid,
                               tx_valid);
                        fail_count++;
                    end
                    if (tx_byte !== head_res.tx_byte)
                    begin
                        $error("tx_byte: expected 0x%02h, actual 0x%02h", head_res.tx_byte,
                               tx_byte);
                        fail_count++;
                    end
                end
            end
            // one long hold-off so the block fills and stalls its input
            if (!long_hold_done && out_count >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (out_count >= 500 && out_count < 650)
                out_ready <= 1'b1;
            else
            begin
                stall_left = ($urandom_range(0, 99) < 25) ? pick_gap() : 0;
                out_ready <= (stall_left == 0);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    int quiet_cycles;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** i2c_target_register_file_core: FAILED **");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    bit         quiet;
    int         kind;
    int         burst;

    initial
    begin
        fail_count       = 0;
        bus_events_added = 0;
        model_ptr        = 8'h00;
        model_phase      = PHASE_IDLE;
        for (int i = 0; i < STORE_DEPTH; i++)
            model_mem[i] = 8'h00;

        // directed: reset contents, idle write, pointer extremes and wraps
        add_item(EV_RD_DATA, 8'h00, 1'b0);
        add_item(EV_WR_DATA, 8'h3C, 1'b0);
        add_item(EV_WR_ADDR, 8'hFF, 1'b0);
        add_item(EV_WR_DATA, 8'(STORE_DEPTH - 1), 1'b0);
        add_item(EV_WR_DATA, 8'hFF, 1'b0);
        add_item(EV_WR_DATA, 8'h00, 1'b0);
        add_item(EV_WR_ADDR, 8'h00, 1'b0);
        add_item(EV_WR_DATA, 8'(STORE_DEPTH - 2), 1'b0);
        add_item(EV_RD_ADDR, 8'h55, 1'b0);
        add_item(EV_RD_DATA, 8'hAA, 1'b0);
        add_item(EV_RD_DATA, 8'h00, 1'b0);
        add_item(EV_WR_ADDR, 8'h00, 1'b0);
        add_item(EV_WR_DATA, 8'd200, 1'b0);
        add_item(EV_WR_DATA, 8'hA5, 1'b0);
        add_item(EV_WR_ADDR, 8'h00, 1'b0);
        add_item(EV_WR_DATA, 8'hFF, 1'b0);
        add_item(EV_RD_DATA, 8'h00, 1'b0);
        add_item(EV_OTHER, 8'hFF, 1'b0);
        add_item(EV_OTHER + 3'd1, 8'h0F, 1'b0);
        add_item(EV_OTHER + 3'd2, 8'hF0, 1'b0);
        add_item(EV_CODE_MAX, 8'h81, 1'b0);
        add_item(EV_WR_DATA, 8'h5A, 1'b0);
        add_item(EV_RD_ADDR, 8'h00, 1'b0);
        add_item(EV_WR_ADDR, 8'h00, 1'b0);
        add_item(EV_RD_DATA, 8'h00, 1'b0);
        add_item(EV_WR_DATA, 8'h01, 1'b0);

        // random: mostly well-formed write and read transfers, some noise
        while (bus_events_added < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 99);
            if (kind < 45)
            begin
                add_item(EV_WR_ADDR, 8'($urandom_range(0, 255)), quiet);
                if ($urandom_range(0, 9) == 0)
                    add_item(EV_WR_DATA, 8'($urandom_range(STORE_DEPTH, 255)), quiet);
                else
                    add_item(EV_WR_DATA, 8'($urandom_range(0, STORE_DEPTH - 1)), quiet);
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst; i++)
                    add_item(EV_WR_DATA, 8'($urandom_range(0, 255)), quiet);
                if ($urandom_range(0, 1) == 0)
                    add_item(EV_OTHER, 8'($urandom_range(0, 255)), quiet);
            end
            else if (kind < 85)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    add_item(EV_WR_ADDR, 8'($urandom_range(0, 255)), quiet);
                    add_item(EV_WR_DATA, 8'($urandom_range(0, STORE_DEPTH - 1)), quiet);
                end
                add_item(EV_RD_ADDR, 8'($urandom_range(0, 255)), quiet);
                burst = $urandom_range(0, 8);
                for (int i = 0; i < burst; i++)
                    add_item(EV_RD_DATA, 8'($urandom_range(0, 255)), quiet);
                add_item(EV_OTHER, 8'($urandom_range(0, 255)), quiet);
            end
            else
            begin
                burst = $urandom_range(1, 4);
                for (int i = 0; i < burst; i++)
                    add_item(3'($urandom_range(0, EV_CODE_MAX)), 8'($urandom_range(0, 255)),
                             quiet);
            end
        end

        // reset once
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every bus event to be taken and every result to arrive
        @(negedge clk);
        while (pending.size() != 0 || in_valid || out_count != in_count)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (tx_expected.size() != 0)
        begin
            $error("%0d expected results never arrived", tx_expected.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** i2c_target_register_file_core: PASSED **");
        else
            $display("** i2c_target_register_file_core: FAILED **");
        $finish;
    end

endmodule
